[hdl/sfe_pkg.sv]
// shared types and constants of the shannon-fano block encoder
// no dependencies

package sfe_pkg;

  localparam int COUNT_BITS    = 16;
  localparam int MAX_CODE_BITS = 32;
  localparam int ALPHABET_SIZE = 256;

  localparam int SYM_W   = 8;
  localparam int DEPTH   = 256;
  localparam int IDX_W   = 9;
  localparam int CODE_W  = 32;
  localparam int LEN_W   = 6;
  localparam int PLEN_W  = 8;
  localparam int KEY_W   = COUNT_BITS + SYM_W;
  localparam int SUM_W   = COUNT_BITS + SYM_W + 1;
  localparam int STK_W   = 2 * SYM_W;

  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_ABSENT   = 2'd1,
    ST_TOO_LONG = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_e;

  typedef enum logic [4:0] {
    OP_NONE, OP_ACCEPT, OP_CNT_WR, OP_ENC, OP_INIT, OP_SORT_CHK, OP_SORT_END,
    OP_POS_INIT, OP_STK_INIT, OP_POP_LD, OP_TOT_ACC, OP_SPL_ACC, OP_APP_WR,
    OP_PUSH_L, OP_PUSH_R, OP_SCAT_WR, OP_FINISH
  } dp_op_e;

  typedef enum logic [4:0] {
    S_IDLE, S_CNT, S_ENC, S_INIT, S_SORT_RD, S_SORT_CHK, S_SORT_END, S_POS,
    S_STK_INIT, S_POP_RD, S_POP_LD, S_TOT_RD, S_TOT_ACC, S_SPL_RD, S_SPL_ACC,
    S_APP_RD, S_APP_WR, S_PUSH_L, S_PUSH_R, S_SCAT_RD, S_SCAT_WR, S_FINISH
  } state_e;

  typedef struct packed {
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
    logic last;
    logic scan_end;
    logic found;
    logic pos_end;
    logic n_zero;
    logic n_one;
    logic at_hi;
    logic stk_empty;
  } dp_stat_t;

endpackage

[hdl/sfe_ctrl.sv]
// sequencer of the shannon-fano block encoder: handshake, counting, encoding, table build
// depends on sfe_pkg

module sfe_ctrl import sfe_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     in_mode_i,
  output logic     in_ready_o,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o
);

  state_e state_q, state_d;
  logic   accept;

  assign in_ready_o = (state_q == S_IDLE) && stat_i.out_free;
  assign accept     = in_ready_o && in_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = in_mode_i ? S_ENC : S_CNT;
        end
      end
      S_CNT:      state_d = stat_i.last ? S_INIT : S_IDLE;
      S_ENC:      state_d = S_IDLE;
      S_INIT:     state_d = S_SORT_RD;
      S_SORT_RD:  state_d = S_SORT_CHK;
      S_SORT_CHK: state_d = stat_i.scan_end ? S_SORT_END : S_SORT_RD;
      S_SORT_END: begin
        if (stat_i.found) begin
          state_d = S_SORT_RD;
        end else begin
          state_d = stat_i.n_zero ? S_FINISH : S_POS;
        end
      end
      S_POS: begin
        if (stat_i.pos_end) begin
          state_d = stat_i.n_one ? S_SCAT_RD : S_STK_INIT;
        end
      end
      S_STK_INIT: state_d = S_POP_RD;
      S_POP_RD:   state_d = S_POP_LD;
      S_POP_LD:   state_d = S_TOT_RD;
      S_TOT_RD:   state_d = S_TOT_ACC;
      S_TOT_ACC:  state_d = stat_i.at_hi ? S_SPL_RD : S_TOT_RD;
      S_SPL_RD:   state_d = S_SPL_ACC;
      S_SPL_ACC:  state_d = stat_i.at_hi ? S_APP_RD : S_SPL_RD;
      S_APP_RD:   state_d = S_APP_WR;
      S_APP_WR:   state_d = stat_i.at_hi ? S_PUSH_L : S_APP_RD;
      S_PUSH_L:   state_d = S_PUSH_R;
      S_PUSH_R:   state_d = stat_i.stk_empty ? S_SCAT_RD : S_POP_RD;
      S_SCAT_RD:  state_d = S_SCAT_WR;
      S_SCAT_WR:  state_d = stat_i.pos_end ? S_FINISH : S_SCAT_RD;
      S_FINISH:   state_d = S_IDLE;
      default:    state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o.op = OP_NONE;
    case (state_q)
      S_IDLE:     cmd_o.op = accept ? OP_ACCEPT : OP_NONE;
      S_CNT:      cmd_o.op = OP_CNT_WR;
      S_ENC:      cmd_o.op = OP_ENC;
      S_INIT:     cmd_o.op = OP_INIT;
      S_SORT_CHK: cmd_o.op = OP_SORT_CHK;
      S_SORT_END: cmd_o.op = OP_SORT_END;
      S_POS:      cmd_o.op = OP_POS_INIT;
      S_STK_INIT: cmd_o.op = OP_STK_INIT;
      S_POP_LD:   cmd_o.op = OP_POP_LD;
      S_TOT_ACC:  cmd_o.op = OP_TOT_ACC;
      S_SPL_ACC:  cmd_o.op = OP_SPL_ACC;
      S_APP_WR:   cmd_o.op = OP_APP_WR;
      S_PUSH_L:   cmd_o.op = OP_PUSH_L;
      S_PUSH_R:   cmd_o.op = OP_PUSH_R;
      S_SCAT_WR:  cmd_o.op = OP_SCAT_WR;
      S_FINISH:   cmd_o.op = OP_FINISH;
      default:    cmd_o.op = OP_NONE;
    endcase
  end

endmodule

[hdl/sfe_dp.sv]
// datapath of the shannon-fano block encoder: counts, sort, code build, tables
// depends on sfe_pkg

module sfe_dp import sfe_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dp_cmd_t           cmd_i,
  output dp_stat_t          stat_o,
  input  logic [SYM_W-1:0]  in_symbol_i,
  input  logic              in_last_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [CODE_W-1:0] out_bits_o,
  output logic [LEN_W-1:0]  out_len_o,
  output logic [1:0]        out_status_o
);

  // memories
  logic [COUNT_BITS-1:0]      cnt_mem [DEPTH];
  logic [KEY_W-1:0]           srt_mem [DEPTH];
  logic [PLEN_W+CODE_W-1:0]   pos_mem [DEPTH];
  logic [LEN_W+CODE_W-1:0]    cw_mem  [DEPTH];
  logic [STK_W-1:0]           stk_mem [DEPTH];

  logic [COUNT_BITS-1:0]    cnt_rd_q;
  logic [KEY_W-1:0]         srt_rd_q;
  logic [PLEN_W+CODE_W-1:0] pos_rd_q;
  logic [LEN_W+CODE_W-1:0]  cw_rd_q;
  logic [STK_W-1:0]         stk_rd_q;

  logic [DEPTH-1:0] cnt_vld_q, len_vld_q;

  logic [SYM_W-1:0] sym_q, lo_q, hi_q, split_q;
  logic             last_q, have_prev_q, found_q, too_long_q, ovf_q;
  logic [IDX_W-1:0] idx_q, n_q, sp_q;
  logic [SUM_W-1:0] total_q, run_q, best_q;
  logic [KEY_W-1:0] prev_key_q, best_key_q;
  logic [1:0]       terr_q;
  logic             out_vld_q;
  logic [CODE_W-1:0] out_bits_q;
  logic [LEN_W-1:0]  out_len_q;
  logic [1:0]        out_st_q;

  logic [SYM_W-1:0]      idx8, cnt_ra, stk_ra;
  logic [COUNT_BITS-1:0] cnt_cur, srt_cnt;
  logic [KEY_W-1:0]      key;
  logic                  cand, sym_ok;
  logic [SUM_W-1:0]      tot_d, run_d, twice, diff;
  logic [PLEN_W-1:0]     plen_d;
  logic [CODE_W-1:0]     pcode_d;

  assign idx8    = idx_q[SYM_W-1:0];
  assign cnt_ra  = (cmd_i.op == OP_ACCEPT) ? in_symbol_i : idx8;
  assign stk_ra  = SYM_W'(sp_q - IDX_W'(1));
  assign sym_ok  = {1'b0, sym_q} < IDX_W'(ALPHABET_SIZE);
  assign cnt_cur = (cmd_i.op == OP_CNT_WR) ?
                   (cnt_vld_q[sym_q] ? cnt_rd_q : '0) :
                   (cnt_vld_q[idx8] ? cnt_rd_q : '0);
  assign key     = {cnt_cur, idx8};
  assign cand    = (cnt_cur != '0) && (!have_prev_q || key > prev_key_q) &&
                   (!found_q || key < best_key_q);
  assign srt_cnt = srt_rd_q[KEY_W-1:SYM_W];
  assign tot_d   = total_q + SUM_W'(srt_cnt);
  assign run_d   = run_q + SUM_W'(srt_cnt);
  assign twice   = {run_d[SUM_W-2:0], 1'b0};
  assign diff    = (total_q >= twice) ? total_q - twice : twice - total_q;
  assign plen_d  = pos_rd_q[PLEN_W+CODE_W-1:CODE_W] + PLEN_W'(1);
  assign pcode_d = {pos_rd_q[CODE_W-2:0], (idx8 > split_q)};

  // memory ports
  always_ff @(posedge clk_i) begin
    cnt_rd_q <= cnt_mem[cnt_ra];
    srt_rd_q <= srt_mem[idx8];
    pos_rd_q <= pos_mem[idx8];
    cw_rd_q  <= cw_mem[in_symbol_i];
    stk_rd_q <= stk_mem[stk_ra];
    if (cmd_i.op == OP_CNT_WR && sym_ok && cnt_cur != CNT_MAX) begin
      cnt_mem[sym_q] <= cnt_cur + COUNT_BITS'(1);
    end
    if (cmd_i.op == OP_SORT_END && found_q) begin
      srt_mem[n_q[SYM_W-1:0]] <= best_key_q;
    end
    if (cmd_i.op == OP_POS_INIT) begin
      pos_mem[idx8] <= {PLEN_W'(n_q == IDX_W'(1)), {CODE_W{1'b0}}};
    end else if (cmd_i.op == OP_APP_WR) begin
      pos_mem[idx8] <= {plen_d, pcode_d};
    end
    if (cmd_i.op == OP_SCAT_WR) begin
      cw_mem[srt_rd_q[SYM_W-1:0]] <= {pos_rd_q[CODE_W+LEN_W-1:CODE_W],
                                      pos_rd_q[CODE_W-1:0]};
    end
    if (cmd_i.op == OP_STK_INIT) begin
      stk_mem[0] <= {SYM_W'(0), SYM_W'(n_q - IDX_W'(1))};
    end else if (cmd_i.op == OP_PUSH_L && split_q > lo_q) begin
      stk_mem[sp_q[SYM_W-1:0]] <= {lo_q, split_q};
    end else if (cmd_i.op == OP_PUSH_R && hi_q > split_q + SYM_W'(1)) begin
      stk_mem[sp_q[SYM_W-1:0]] <= {split_q + SYM_W'(1), hi_q};
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_ACCEPT: begin
        sym_q  <= in_symbol_i;
        last_q <= in_last_i;
      end
      OP_INIT: begin
        idx_q <= '0;
        n_q   <= '0;
      end
      OP_SORT_CHK: begin
        if (cand) begin
          best_key_q <= key;
        end
        idx_q <= idx_q + IDX_W'(1);
      end
      OP_SORT_END: begin
        idx_q <= '0;
        if (found_q) begin
          n_q        <= n_q + IDX_W'(1);
          prev_key_q <= best_key_q;
        end
      end
      OP_POS_INIT: begin
        idx_q <= (idx_q + IDX_W'(1) == n_q) ? '0 : idx_q + IDX_W'(1);
      end
      OP_POP_LD: begin
        lo_q    <= stk_rd_q[STK_W-1:SYM_W];
        hi_q    <= stk_rd_q[SYM_W-1:0];
        idx_q   <= {1'b0, stk_rd_q[STK_W-1:SYM_W]};
        total_q <= '0;
      end
      OP_TOT_ACC: begin
        total_q <= tot_d;
        if (idx8 == hi_q) begin
          idx_q   <= {1'b0, lo_q};
          best_q  <= tot_d;
          run_q   <= '0;
          split_q <= lo_q;
        end else begin
          idx_q <= idx_q + IDX_W'(1);
        end
      end
      OP_SPL_ACC: begin
        run_q <= run_d;
        if (diff < best_q) begin
          best_q  <= diff;
          split_q <= idx8;
        end
        idx_q <= (idx8 == hi_q) ? {1'b0, lo_q} : idx_q + IDX_W'(1);
      end
      OP_APP_WR:  idx_q <= idx_q + IDX_W'(1);
      OP_PUSH_R:  idx_q <= '0;
      OP_SCAT_WR: idx_q <= idx_q + IDX_W'(1);
      default: ;
    endcase
    if (cmd_i.op == OP_ENC) begin
      if (terr_q != ST_OK) begin
        out_st_q   <= terr_q;
        out_bits_q <= '0;
        out_len_q  <= '0;
      end else if (!sym_ok || !len_vld_q[sym_q]) begin
        out_st_q   <= ST_ABSENT;
        out_bits_q <= '0;
        out_len_q  <= '0;
      end else begin
        out_st_q   <= ST_OK;
        out_bits_q <= cw_rd_q[CODE_W-1:0];
        out_len_q  <= cw_rd_q[LEN_W+CODE_W-1:CODE_W];
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_vld_q   <= '0;
      len_vld_q   <= '0;
      have_prev_q <= 1'b0;
      found_q     <= 1'b0;
      too_long_q  <= 1'b0;
      ovf_q       <= 1'b0;
      terr_q      <= ST_OK;
      sp_q        <= '0;
      out_vld_q   <= 1'b0;
    end else begin
      if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
      case (cmd_i.op)
        OP_CNT_WR: begin
          if (sym_ok) begin
            if (cnt_cur == CNT_MAX) begin
              ovf_q <= 1'b1;
            end else begin
              cnt_vld_q[sym_q] <= 1'b1;
            end
          end
        end
        OP_ENC: out_vld_q <= 1'b1;
        OP_INIT: begin
          len_vld_q   <= '0;
          have_prev_q <= 1'b0;
          found_q     <= 1'b0;
          too_long_q  <= 1'b0;
        end
        OP_SORT_CHK: begin
          if (cand) begin
            found_q <= 1'b1;
          end
        end
        OP_SORT_END: begin
          if (found_q) begin
            have_prev_q <= 1'b1;
          end
          found_q <= 1'b0;
        end
        OP_STK_INIT: sp_q <= IDX_W'(1);
        OP_POP_LD:   sp_q <= sp_q - IDX_W'(1);
        OP_APP_WR: begin
          if ({1'b0, plen_d} > (PLEN_W+1)'(MAX_CODE_BITS)) begin
            too_long_q <= 1'b1;
          end
        end
        OP_PUSH_L: begin
          if (split_q > lo_q) begin
            sp_q <= sp_q + IDX_W'(1);
          end
        end
        OP_PUSH_R: begin
          if (hi_q > split_q + SYM_W'(1)) begin
            sp_q <= sp_q + IDX_W'(1);
          end
        end
        OP_SCAT_WR: len_vld_q[srt_rd_q[SYM_W-1:0]] <= 1'b1;
        OP_FINISH: begin
          terr_q    <= ovf_q ? ST_OVERFLOW : (too_long_q ? ST_TOO_LONG : ST_OK);
          ovf_q     <= 1'b0;
          cnt_vld_q <= '0;
        end
        default: ;
      endcase
    end
  end

  assign stat_o.out_free  = !out_vld_q || out_ready_i;
  assign stat_o.last      = last_q;
  assign stat_o.scan_end  = idx_q == IDX_W'(ALPHABET_SIZE - 1);
  assign stat_o.found     = found_q;
  assign stat_o.pos_end   = (idx_q + IDX_W'(1)) == n_q;
  assign stat_o.n_zero    = n_q == '0;
  assign stat_o.n_one     = n_q == IDX_W'(1);
  assign stat_o.at_hi     = idx8 == hi_q;
  assign stat_o.stk_empty = (sp_q == '0) && !(hi_q > split_q + SYM_W'(1));

  assign out_valid_o  = out_vld_q;
  assign out_bits_o   = out_bits_q;
  assign out_len_o    = out_len_q;
  assign out_status_o = out_st_q;

endmodule

[hdl/shannon_fano_block_encoder_core.sv]
// top level of the shannon-fano block encoder: sequencer plus datapath
// depends on sfe_pkg, sfe_ctrl, sfe_dp

// Two-pass byte encoder. Count items (tuser=0) read the symbol's count when
// accepted and write it back in state S_CNT; the next item is accepted only
// after that write. The count item with tlast set ends the block and starts
// the table build, during which no item is accepted. The build sorts the seen
// symbols by a selection scan over the count memory, one full scan per distinct
// symbol plus one; then the recursive splitting walks each range three times,
// and a final pass copies codes into the per-symbol table. Encode items
// (tuser=1) read that table when accepted and return one result from state
// S_ENC: code right-aligned in tdata[31:0], length in tdata[37:32], status in
// tuser. Reset needs no clearing pass.

module shannon_fano_block_encoder_core import sfe_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] symbol
  input  logic        s_axis_tuser,   // [0] mode: 0 count, 1 encode
  input  logic        s_axis_tlast,   // last item of the block
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [31:0] code_bits, [37:32] code_length, zero pad
  output logic [1:0]  m_axis_tuser    // [1:0] status
);

  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic [CODE_W-1:0] bits;
  logic [LEN_W-1:0]  len;

  // sequencer owns the input handshake and steps the datapath
  sfe_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_mode_i  (s_axis_tuser),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // datapath holds all memories and the output register
  sfe_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .in_symbol_i  (s_axis_tdata),
    .in_last_i    (s_axis_tlast),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_bits_o   (bits),
    .out_len_o    (len),
    .out_status_o (m_axis_tuser)
  );

  assign m_axis_tdata = {2'b00, len, bits};

endmodule

[hdl/sfe_checker.sv]
// port-level checks of the shannon-fano block encoder, bound to the top level
// depends on sfe_pkg

module sfe_checker import sfe_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser
);

  // a waiting item holds until taken
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output item changed while stalled");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != ST_OK |-> m_axis_tdata == '0)
    else $error("error item carries code bits");

  a_ok_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == ST_OK |->
      m_axis_tdata[37:32] != 6'd0 && m_axis_tdata[37:32] <= 6'd32)
    else $error("ok item with bad length");

  // an accepted item is never followed by an immediate second accept
  a_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted back to back");

endmodule

bind shannon_fano_block_encoder_core sfe_checker u_sfe_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

[tb/tb_shannon_fano_block_encoder_core.sv]
// self-checking testbench of shannon_fano_block_encoder_core
// depends on sfe_pkg and the encoder rtl; an internal code table predictor
`timescale 1ns / 100ps

module tb_shannon_fano_block_encoder_core;
  import sfe_pkg::*;

  localparam int  CYCLE_LIMIT = 4000000;
  localparam int  TAIL_CYCLES = 64;
  localparam int  RAND_ITEMS  = 820;
  localparam bit  MODE_COUNT  = 1'b0;
  localparam bit  MODE_ENCODE = 1'b1;

  typedef struct packed {
    logic [CODE_W-1:0] bits;
    logic [LEN_W-1:0]  len;
    status_e           st;
  } code_item_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;

  // predictor state
  int unsigned       sym_count [DEPTH];
  longint unsigned   code_bits [DEPTH];
  int unsigned       code_len [DEPTH];
  bit                ovf_pending;
  status_e           table_err;

  code_item_t        pending_codes [$];
  int                gap_pct;
  int                stall_pct;
  int                mismatches;
  int                sent_items;
  int unsigned       cycles;

  shannon_fano_block_encoder_core uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("shannon_fano_block_encoder_core regression: fail");
      $finish;
    end
  end

  // build the code table from the counts of the finished block
  function automatic void build_code_table();
    int unsigned     order [DEPTH];
    int unsigned     ranges [$];
    int unsigned     n, j, lo, hi, split, rng;
    longint unsigned total, run, best, twice, diff;
    bit              too_long;
    n = 0;
    too_long = 0;
    foreach (code_bits[k]) begin
      code_bits[k] = 0;
      code_len[k] = 0;
    end
    // stable insertion over ascending symbols keeps ties in symbol order
    for (int s = 0; s < DEPTH; s++) begin
      if (sym_count[s] != 0) begin
        j = n;
        while (j > 0 && sym_count[order[j-1]] > sym_count[s]) begin
          order[j] = order[j-1];
          j--;
        end
        order[j] = s;
        n++;
      end
    end
    if (n == 1) begin
      code_len[order[0]] = 1;
    end else if (n >= 2) begin
      ranges = {ranges, n - 1};
      while (ranges.size() > 0) begin
        rng = ranges.pop_back();
        lo = rng >> 8;
        hi = rng & 8'hff;
        total = 0;
        run = 0;
        split = lo;
        for (int i = lo; i <= hi; i++) total += sym_count[order[i]];
        best = total;
        for (int i = lo; i <= hi; i++) begin
          run += sym_count[order[i]];
          twice = run * 2;
          diff = (total >= twice) ? total - twice : twice - total;
          if (diff < best) begin
            best = diff;
            split = i;
          end
        end
        for (int i = lo; i <= hi; i++) begin
          code_bits[order[i]] = (code_bits[order[i]] << 1) | ((i > split) ? 1 : 0);
          code_len[order[i]]++;
          if (code_len[order[i]] > MAX_CODE_BITS) too_long = 1;
        end
        if (split > lo && ranges.size() < DEPTH) ranges = {ranges, (lo << 8) | split};
        if (hi > split + 1 && ranges.size() < DEPTH)
          ranges = {ranges, ((split + 1) << 8) | hi};
      end
    end
    table_err = ovf_pending ? ST_OVERFLOW : (too_long ? ST_TOO_LONG : ST_OK);
    ovf_pending = 0;
    foreach (sym_count[k]) sym_count[k] = 0;
  endfunction

  // apply one accepted item to the predictor
  function automatic void predict_code(bit mode, logic [7:0] sym, bit last);
    code_item_t c;
    if (mode == MODE_COUNT) begin
      if (sym_count[sym] >= CNT_MAX) ovf_pending = 1;
      else sym_count[sym]++;
      if (last) build_code_table();
    end else begin
      c = '{bits: '0, len: '0, st: ST_OK};
      if (table_err != ST_OK) c.st = table_err;
      else if (code_len[sym] == 0) c.st = ST_ABSENT;
      else begin
        c.bits = code_bits[sym][CODE_W-1:0];
        c.len = code_len[sym][LEN_W-1:0];
      end
      pending_codes = {pending_codes, c};
    end
  endfunction

  // send one item; tvalid stays high across back-to-back items
  task automatic send_item(bit mode, logic [7:0] sym, bit last);
    if ($urandom_range(99) < gap_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < gap_pct) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= sym;
    s_axis_tuser <= mode;
    s_axis_tlast <= last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_code(mode, sym, last);
    sent_items++;
  endtask

  // sender holds off until every expected code has come back
  task automatic drain_codes();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_codes.size() != 0) @(posedge clk_i);
  endtask

  // result checker and receiver stalls
  always @(posedge clk_i) begin
    code_item_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_codes.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected item: tdata %h status %0d",
                                         m_axis_tdata, m_axis_tuser);
        end else begin
          want = pending_codes.pop_front();
          if (m_axis_tdata[31:0] !== want.bits || m_axis_tdata[37:32] !== want.len ||
              m_axis_tuser !== want.st) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: want bits %h len %0d st %0d, got bits %h len %0d st %0d",
                       want.bits, want.len, want.st, m_axis_tdata[31:0],
                       m_axis_tdata[37:32], m_axis_tuser);
          end
        end
      end
      m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic test_no_table();
    send_item(MODE_ENCODE, 8'h00, 1'b0);
    send_item(MODE_ENCODE, 8'hff, 1'b1);
    send_item(MODE_ENCODE, 8'h5a, 1'b0);
  endtask

  task automatic test_single_symbol();
    repeat (2) send_item(MODE_COUNT, 8'haa, 1'b0);
    send_item(MODE_COUNT, 8'haa, 1'b1);
    send_item(MODE_ENCODE, 8'haa, 1'b0);
    send_item(MODE_ENCODE, 8'h55, 1'b0);
  endtask

  task automatic test_extremes_and_ties();
    send_item(MODE_COUNT, 8'hff, 1'b0);
    send_item(MODE_COUNT, 8'h00, 1'b0);
    send_item(MODE_COUNT, 8'h80, 1'b0);
    send_item(MODE_COUNT, 8'h80, 1'b0);
    send_item(MODE_COUNT, 8'h01, 1'b1);
    send_item(MODE_ENCODE, 8'h00, 1'b0);
    send_item(MODE_ENCODE, 8'h01, 1'b1);
    send_item(MODE_ENCODE, 8'h80, 1'b0);
    send_item(MODE_ENCODE, 8'hff, 1'b0);
    send_item(MODE_ENCODE, 8'h7f, 1'b0);
    drain_codes();
  endtask

  // every symbol once: a tie across the whole alphabet, longest build
  task automatic test_full_alphabet();
    for (int s = 0; s < DEPTH; s++) send_item(MODE_COUNT, s[7:0], s == DEPTH - 1);
    repeat (20) send_item(MODE_ENCODE, 8'($urandom_range(255)), 1'b0);
  endtask

  // fibonacci counts give the deepest codes for few items
  task automatic test_skewed_counts();
    int a, b, t;
    a = 1;
    b = 1;
    for (int s = 0; s < 12; s++) begin
      repeat (a) send_item(MODE_COUNT, 8'(s * 21), 1'b0);
      t = a + b;
      a = b;
      b = t;
    end
    send_item(MODE_COUNT, 8'd3, 1'b1);
    for (int s = 0; s < 12; s++) send_item(MODE_ENCODE, 8'(s * 21), 1'b0);
  endtask

  // random blocks over a small pool, then encodes; some noise in between
  task automatic test_random_blocks();
    logic [7:0] pool [10];
    int         npool, len, start;
    start = sent_items;
    while (sent_items - start < RAND_ITEMS) begin
      case ((sent_items - start) * 4 / RAND_ITEMS)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 58; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 58; end
        default: begin gap_pct = 25; stall_pct = 25; end
      endcase
      npool = $urandom_range(10, 1);
      for (int k = 0; k < npool; k++) pool[k] = 8'($urandom_range(255));
      len = $urandom_range(40, 3);
      for (int k = 0; k < len; k++) begin
        if ($urandom_range(9) == 0)
          send_item(MODE_ENCODE, 8'($urandom_range(255)), 1'($urandom_range(1)));
        else
          send_item(MODE_COUNT, pool[$urandom_range(npool - 1)], 1'b0);
      end
      send_item(MODE_COUNT, pool[$urandom_range(npool - 1)], 1'b1);
      len = $urandom_range(40, 5);
      for (int k = 0; k < len; k++) begin
        if ($urandom_range(7) == 0)
          send_item(MODE_ENCODE, 8'($urandom_range(255)), 1'($urandom_range(1)));
        else
          send_item(MODE_ENCODE, pool[$urandom_range(npool - 1)],
                    1'($urandom_range(1)));
      end
    end
  endtask

  initial begin
    mismatches = 0;
    sent_items = 0;
    cycles = 0;
    gap_pct = 0;
    stall_pct = 0;
    ovf_pending = 0;
    table_err = ST_OK;
    foreach (sym_count[k]) begin
      sym_count[k] = 0;
      code_bits[k] = 0;
      code_len[k] = 0;
    end
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_no_table();
    test_single_symbol();
    test_extremes_and_ties();
    gap_pct = 25;
    stall_pct = 25;
    test_full_alphabet();
    test_skewed_counts();
    gap_pct = 0;
    stall_pct = 0;
    drain_codes();
    test_random_blocks();

    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_codes.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && pending_codes.size() == 0)
      $display("shannon_fano_block_encoder_core regression: pass");
    else
      $display("shannon_fano_block_encoder_core regression: fail");
    $finish;
  end

endmodule
